[hw/rtl/edf_pkg.sv]
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared types and constants of the earliest-deadline-first task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

  // Default number of task slots.
  localparam int unsigned EdfSlots = 8;

  // Field widths of the command and result words.
  localparam int unsigned TimeW = 8;
  localparam int unsigned SlotW = 3;

  // Largest value of the elapsed counter; it saturates there.
  localparam logic [TimeW-1:0] ElapsedMax = {TimeW{1'b1}};

  // Command codes.
  typedef enum logic [0:0] {
    OP_CREATE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  // Command word.
  typedef struct packed {
    opcode_e          opcode;
    logic [TimeW-1:0] exec_time;
    logic [TimeW-1:0] deadline;
  } edf_req_t;

  // Result word.
  typedef struct packed {
    logic             accepted;
    logic [SlotW-1:0] assigned_slot;
    logic             running_valid;
    logic [SlotW-1:0] running_slot;
    logic             finished;
    logic [SlotW-1:0] finished_slot;
    logic [TimeW-1:0] finished_elapsed;
    logic [TimeW-1:0] finished_slack;
    logic             deadline_missed;
    logic             all_done;
  } edf_res_t;

  // One entry of the task memory.
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] remaining;
    logic [TimeW-1:0] elapsed;
  } task_entry_t;

endpackage

`default_nettype wire

[hw/rtl/edf_task_scheduler.sv]
// ----------------------------------------------------------------------------
// EDF task scheduler
// Non-preemptive earliest-deadline-first scheduler over a table of task slots
// held in a synchronous memory with separate read and write ports.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           word
//   command   in         start, busy         req_i (edf_req_t)
//   result    out        done_o strobe       res_o (edf_res_t)
//
// A create, or any command while halted, pulses done_o in the next cycle
// while busy stays low. A tick of a running task that does not finish
// reads the task from memory, then writes it back in ST_UPDATE. A tick
// that finishes a task, or a tick with no task running, adds a scan of the
// task memory, one slot read per cycle. Reset clears the valid bits and the
// control state; the memory itself needs no clearing. The receiver cannot
// stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module edf_task_scheduler #(
  parameter int unsigned SLOTS = edf_pkg::EdfSlots
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire edf_pkg::edf_req_t req_i,
  output      logic              done_o,
  output      edf_pkg::edf_res_t res_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FullCnt = CW'(SLOTS);
  localparam int unsigned TW = edf_pkg::TimeW;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_UPDATE   = 4'b0010,
    ST_SCAN     = 4'b0100,
    ST_SCAN_END = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]    count_q, count_d;
  logic             cur_valid_q, cur_valid_d;
  logic [IW-1:0]    cur_slot_q, cur_slot_d;
  logic             halted_q, halted_d;

  // Finish information of the current tick.
  logic             fin_q, fin_d;
  logic [IW-1:0]    fin_slot_q, fin_slot_d;
  logic [TW-1:0]    fin_elapsed_q, fin_elapsed_d;
  logic [TW-1:0]    fin_slack_q, fin_slack_d;

  // Scan of the task memory.
  logic [IW-1:0]    scan_idx_q, scan_idx_d;
  logic             cmp_vld_q;
  logic [IW-1:0]    cmp_idx_q;
  logic             found_q, found_d;
  logic [TW-1:0]    best_dl_q, best_dl_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;

  // Result register.
  logic              done_q, done_d;
  logic              acc_d;
  edf_pkg::edf_res_t res_q, res_d;

  // Task memory: a read port and a write port, registered read data.
  edf_pkg::task_entry_t mem_q [SLOTS];
  edf_pkg::task_entry_t rd_data_q;
  edf_pkg::task_entry_t wr_data;
  edf_pkg::task_entry_t upd;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [IW-1:0]        rd_addr;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Read address: the running task on a tick, the scan pointer during a scan.
  always_comb begin
    rd_addr = cur_slot_q;
    if (state_q == ST_SCAN) begin
      rd_addr = scan_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Saturating update of the running task.
  always_comb begin
    upd.deadline  = (rd_data_q.deadline != '0) ? rd_data_q.deadline - 1'b1 : '0;
    upd.remaining = (rd_data_q.remaining != '0) ? rd_data_q.remaining - 1'b1 : '0;
    upd.elapsed   = (rd_data_q.elapsed != edf_pkg::ElapsedMax) ?
                    rd_data_q.elapsed + 1'b1 : edf_pkg::ElapsedMax;
  end

  // Running minimum over the scanned slots; strict compare keeps the lowest index.
  always_comb begin
    found_d    = found_q;
    best_dl_d  = best_dl_q;
    best_idx_d = best_idx_q;
    if (cmp_vld_q && valid_q[cmp_idx_q] &&
        (!found_q || (rd_data_q.deadline < best_dl_q))) begin
      found_d    = 1'b1;
      best_dl_d  = rd_data_q.deadline;
      best_idx_d = cmp_idx_q;
    end
  end

  // Main control.
  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    count_d       = count_q;
    cur_valid_d   = cur_valid_q;
    cur_slot_d    = cur_slot_q;
    halted_d      = halted_q;
    fin_d         = fin_q;
    fin_slot_d    = fin_slot_q;
    fin_elapsed_d = fin_elapsed_q;
    fin_slack_d   = fin_slack_q;
    scan_idx_d    = scan_idx_q;
    done_d        = 1'b0;
    acc_d         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_q[IW-1:0];
    wr_data       = upd;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fin_d = 1'b0;
          if (halted_q) begin
            done_d = 1'b1;
          end else if (req_i.opcode == edf_pkg::OP_CREATE) begin
            done_d = 1'b1;
            if (count_q != FullCnt) begin
              acc_d                      = 1'b1;
              wr_en                      = 1'b1;
              wr_data.deadline           = req_i.deadline;
              wr_data.remaining          = req_i.exec_time;
              wr_data.elapsed            = '0;
              valid_d[count_q[IW-1:0]]   = 1'b1;
              count_d                    = count_q + 1'b1;
            end
          end else if (cur_valid_q) begin
            state_d = ST_UPDATE;
          end else begin
            scan_idx_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_UPDATE: begin
        wr_en   = 1'b1;
        wr_addr = cur_slot_q;
        if (upd.remaining == '0) begin
          fin_d               = 1'b1;
          fin_slot_d          = cur_slot_q;
          fin_elapsed_d       = upd.elapsed;
          fin_slack_d         = upd.deadline;
          valid_d[cur_slot_q] = 1'b0;
          cur_valid_d         = 1'b0;
          scan_idx_d          = '0;
          state_d             = ST_SCAN;
        end else begin
          if (upd.deadline == '0) begin
            halted_d = 1'b1;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (scan_idx_q == LastIdx) begin
          state_d = ST_SCAN_END;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end

      ST_SCAN_END: begin
        cur_valid_d = found_d;
        cur_slot_d  = found_d ? best_idx_d : '0;
        done_d      = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Slot numbers in the result keep their low three bits.
  logic [IW+2:0] asg_ext, run_ext, fin_ext;
  assign asg_ext = {3'b000, count_q[IW-1:0]};
  assign run_ext = {3'b000, cur_slot_d};
  assign fin_ext = {3'b000, fin_slot_d};

  // Result word, built from the state after this command.
  always_comb begin
    res_d                  = res_q;
    if (done_d) begin
      res_d.accepted         = acc_d;
      res_d.assigned_slot    = acc_d ? asg_ext[2:0] : '0;
      res_d.running_valid    = cur_valid_d;
      res_d.running_slot     = cur_valid_d ? run_ext[2:0] : '0;
      res_d.finished         = fin_d;
      res_d.finished_slot    = fin_d ? fin_ext[2:0] : '0;
      res_d.finished_elapsed = fin_d ? fin_elapsed_d : '0;
      res_d.finished_slack   = fin_d ? fin_slack_d : '0;
      res_d.deadline_missed  = halted_d;
      res_d.all_done         = (count_d == FullCnt) && !(|valid_d);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      halted_q    <= 1'b0;
      fin_q       <= 1'b0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      halted_q    <= halted_d;
      fin_q       <= fin_d;
      cmp_vld_q   <= (state_q == ST_SCAN);
      found_q     <= (state_q == ST_SCAN || state_q == ST_SCAN_END) ? found_d : 1'b0;
      done_q      <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    fin_slot_q    <= fin_slot_d;
    fin_elapsed_q <= fin_elapsed_d;
    fin_slack_q   <= fin_slack_d;
    scan_idx_q    <= scan_idx_d;
    cmp_idx_q     <= scan_idx_q;
    best_dl_q     <= best_dl_d;
    best_idx_q    <= best_idx_d;
    res_q         <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every result comes with the block ready for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while busy");

  // A missed deadline halts the block for good.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halt released");

  // The current task always sits in a live slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cur_valid_q |-> valid_q[cur_slot_q])
    else $error("current task in a free slot");

  // A task that finishes never reports a miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && res_o.finished) |-> !res_o.deadline_missed)
    else $error("finish and miss on one tick");

endmodule

`default_nettype wire
